/* rtl/core/config_rom_directory_parser_top_assert.svh */
// assertion macros shared by the config rom parser rtl
`ifndef CONFIG_ROM_DIRECTORY_PARSER_TOP_ASSERT_SVH
`define CONFIG_ROM_DIRECTORY_PARSER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CRDP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CRDP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/crdp_pkg.sv */
// types and constants shared by the config rom parser
package crdp_pkg;

    localparam int NUM_SLOTS = 7;

    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_BADMAGIC = 3'd2;
    localparam logic [2:0] ST_FETCHERR = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    typedef struct packed {
        logic        action;
        logic [31:0] rom_word;
        logic        fetch_failed;
    } quad_t;

    typedef struct packed {
        logic        record_valid;
        logic [3:0]  record_kind;
        logic [31:0] record_value;
        logic [9:0]  next_offset;
        logic        fetch_more;
        logic [2:0]  walk_status;
        logic        last;
    } res_t;

    // all records caused by one word, plus the fields they share
    typedef struct packed {
        logic [2:0]                      count;
        logic                            decoded;
        logic [NUM_SLOTS-1:0][3:0]       kind;
        logic [NUM_SLOTS-1:0][31:0]      value;
        logic [9:0]                      next_offset;
        logic                            fetch_more;
        logic [2:0]                      walk_status;
    } batch_t;

endpackage

/* rtl/core/crdp_walk.sv */
// walk state and decode of one fetched quadlet into a batch of records
module crdp_walk #(
    parameter int MAX_DIR_ENTRIES = 16,
    parameter int ROM_ADDR_BITS   = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  crdp_pkg::quad_t  quad,
    output crdp_pkg::batch_t batch
);
    import crdp_pkg::*;

    localparam int AW = ROM_ADDR_BITS;

    localparam logic [31:0] ROM_MAGIC  = 32'h3133_3934;
    localparam logic [7:0]  KEY_VENDOR = 8'h03;
    localparam logic [7:0]  KEY_CAPS   = 8'h0c;
    localparam logic [7:0]  KEY_UNIT   = 8'hd1;
    localparam logic [7:0]  KEY_TEXT   = 8'h81;
    localparam logic [7:0]  KEY_SPEC   = 8'h12;
    localparam logic [7:0]  KEY_SWVER  = 8'h13;
    localparam logic [7:0]  KEY_MODEL  = 8'h17;

    localparam logic [3:0] K_VENDOR   = 4'd0;
    localparam logic [3:0] K_IRM      = 4'd1;
    localparam logic [3:0] K_CYCMST   = 4'd2;
    localparam logic [3:0] K_ISO      = 4'd3;
    localparam logic [3:0] K_BUSMGR   = 4'd4;
    localparam logic [3:0] K_ACCURACY = 4'd5;
    localparam logic [3:0] K_PAYLOAD  = 4'd6;
    localparam logic [3:0] K_SPEED    = 4'd7;
    localparam logic [3:0] K_GUIDHI   = 4'd8;
    localparam logic [3:0] K_GUIDLO   = 4'd9;
    localparam logic [3:0] K_NODECAPS = 4'd10;
    localparam logic [3:0] K_SPEC     = 4'd11;
    localparam logic [3:0] K_SWVER    = 4'd12;
    localparam logic [3:0] K_MODEL    = 4'd13;
    localparam logic [3:0] K_TEXTLEAF = 4'd14;
    localparam logic [3:0] K_VMISMTCH = 4'd15;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_HDR     = 10'b00_0000_0010,
        PH_MAGIC   = 10'b00_0000_0100,
        PH_CAPS    = 10'b00_0000_1000,
        PH_VEND    = 10'b00_0001_0000,
        PH_GUIDLO  = 10'b00_0010_0000,
        PH_ROOTHDR = 10'b00_0100_0000,
        PH_ROOTENT = 10'b00_1000_0000,
        PH_UNITHDR = 10'b01_0000_0000,
        PH_UNITENT = 10'b10_0000_0000
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [AW-1:0] off_reg, off_next;
    logic [4:0]    left_reg, left_next;
    logic [AW-1:0] udp_reg, udp_next;
    logic [23:0]   vend_reg, vend_next;

    logic [31:0]   w;
    logic [7:0]    key;
    logic [23:0]   val;
    logic [AW:0]   off_inc;
    logic [31:0]   ptr32;
    logic          ptr_oob;
    logic [15:0]   dir_len;
    logic [4:0]    len_cap;
    logic [4:0]    left_dec;

    logic          do_req;
    logic [AW:0]   req_off;
    phase_t        req_phase;
    logic          do_end;
    logic [2:0]    end_status;
    logic [31:0]   off32;

    assign w        = quad.rom_word;
    assign key      = w[31:24];
    assign val      = w[23:0];
    assign off_inc  = {1'b0, off_reg} + (AW+1)'(4);
    assign ptr32    = 32'(off_reg) + {6'b0, val, 2'b00};
    assign ptr_oob  = (ptr32 >> AW) != 32'd0;
    assign dir_len  = w[31:16];
    assign len_cap  = (dir_len > 16'(MAX_DIR_ENTRIES)) ? 5'(MAX_DIR_ENTRIES) : dir_len[4:0];
    assign left_dec = left_reg - 5'd1;

    always_comb
    begin
        phase_next = phase_reg;
        off_next   = off_reg;
        left_next  = left_reg;
        udp_next   = udp_reg;
        vend_next  = vend_reg;
        do_req     = 1'b0;
        req_off    = '0;
        req_phase  = PH_IDLE;
        do_end     = 1'b0;
        end_status = ST_DONE;
        batch      = '0;
        batch.count = 3'd1;

        if (!quad.action) begin
            left_next = '0;
            udp_next  = '0;
            vend_next = '0;
            do_req    = 1'b1;
            req_phase = PH_HDR;
        end else if (phase_reg == PH_IDLE) begin
            // quadlet with no walk running produces nothing
            batch.count = 3'd0;
        end else if (quad.fetch_failed) begin
            do_end     = 1'b1;
            end_status = ST_FETCHERR;
        end else begin
            case (phase_reg)
                PH_HDR:
                begin
                    if (key != 8'd4) begin
                        batch.decoded  = 1'b1;
                        batch.kind[0]  = K_VENDOR;
                        batch.value[0] = {8'd0, val};
                        do_end         = 1'b1;
                    end else begin
                        do_req    = 1'b1;
                        req_off   = off_inc;
                        req_phase = PH_MAGIC;
                    end
                end
                PH_MAGIC:
                begin
                    if (w != ROM_MAGIC) begin
                        do_end     = 1'b1;
                        end_status = ST_BADMAGIC;
                    end else begin
                        do_req    = 1'b1;
                        req_off   = off_inc;
                        req_phase = PH_CAPS;
                    end
                end
                PH_CAPS:
                begin
                    batch.decoded  = 1'b1;
                    batch.count    = 3'd7;
                    batch.kind[0]  = K_IRM;
                    batch.value[0] = {31'd0, w[31]};
                    batch.kind[1]  = K_CYCMST;
                    batch.value[1] = {31'd0, w[30]};
                    batch.kind[2]  = K_ISO;
                    batch.value[2] = {31'd0, w[29]};
                    batch.kind[3]  = K_BUSMGR;
                    batch.value[3] = {31'd0, w[28]};
                    batch.kind[4]  = K_ACCURACY;
                    batch.value[4] = {24'd0, w[23:16]};
                    batch.kind[5]  = K_PAYLOAD;
                    batch.value[5] = 32'd2 << w[15:12];
                    batch.kind[6]  = K_SPEED;
                    batch.value[6] = {29'd0, w[2:0]};
                    do_req         = 1'b1;
                    req_off        = off_inc;
                    req_phase      = PH_VEND;
                end
                PH_VEND:
                begin
                    vend_next      = w[31:8];
                    batch.decoded  = 1'b1;
                    batch.count    = 3'd2;
                    batch.kind[0]  = K_VENDOR;
                    batch.value[0] = {8'd0, w[31:8]};
                    batch.kind[1]  = K_GUIDHI;
                    batch.value[1] = {24'd0, w[7:0]};
                    do_req         = 1'b1;
                    req_off        = off_inc;
                    req_phase      = PH_GUIDLO;
                end
                PH_GUIDLO:
                begin
                    batch.decoded  = 1'b1;
                    batch.kind[0]  = K_GUIDLO;
                    batch.value[0] = w;
                    do_req         = 1'b1;
                    req_off        = off_inc;
                    req_phase      = PH_ROOTHDR;
                end
                PH_ROOTHDR:
                begin
                    left_next = len_cap;
                    if (len_cap == 5'd0) begin
                        if (udp_reg != '0) begin
                            do_req    = 1'b1;
                            req_off   = {1'b0, udp_reg};
                            req_phase = PH_UNITHDR;
                        end else begin
                            do_end = 1'b1;
                        end
                    end else begin
                        do_req    = 1'b1;
                        req_off   = off_inc;
                        req_phase = PH_ROOTENT;
                    end
                end
                PH_ROOTENT:
                begin
                    if ((key == KEY_UNIT || key == KEY_TEXT) && ptr_oob) begin
                        do_end     = 1'b1;
                        end_status = ST_RANGE;
                    end else begin
                        if (key == KEY_CAPS) begin
                            batch.decoded  = 1'b1;
                            batch.kind[0]  = K_NODECAPS;
                            batch.value[0] = {8'd0, val};
                        end else if (key == KEY_VENDOR) begin
                            if (val != vend_reg) begin
                                batch.decoded  = 1'b1;
                                batch.kind[0]  = K_VMISMTCH;
                                batch.value[0] = {8'd0, val};
                            end
                        end else if (key == KEY_UNIT) begin
                            udp_next = ptr32[AW-1:0];
                        end else if (key == KEY_TEXT) begin
                            batch.decoded  = 1'b1;
                            batch.kind[0]  = K_TEXTLEAF;
                            batch.value[0] = 32'(ptr32[AW-1:0]);
                        end
                        left_next = left_dec;
                        if (left_dec == 5'd0) begin
                            // last root entry: go to the unit directory if one was seen
                            if (udp_next != '0) begin
                                do_req    = 1'b1;
                                req_off   = {1'b0, udp_next};
                                req_phase = PH_UNITHDR;
                            end else begin
                                do_end = 1'b1;
                            end
                        end else begin
                            do_req    = 1'b1;
                            req_off   = off_inc;
                            req_phase = PH_ROOTENT;
                        end
                    end
                end
                PH_UNITHDR:
                begin
                    left_next = len_cap;
                    if (len_cap == 5'd0) begin
                        do_end = 1'b1;
                    end else begin
                        do_req    = 1'b1;
                        req_off   = off_inc;
                        req_phase = PH_UNITENT;
                    end
                end
                PH_UNITENT:
                begin
                    if (key == KEY_SPEC) begin
                        batch.decoded  = 1'b1;
                        batch.kind[0]  = K_SPEC;
                        batch.value[0] = {8'd0, val};
                    end else if (key == KEY_SWVER) begin
                        batch.decoded  = 1'b1;
                        batch.kind[0]  = K_SWVER;
                        batch.value[0] = {8'd0, val};
                    end else if (key == KEY_MODEL) begin
                        batch.decoded  = 1'b1;
                        batch.kind[0]  = K_MODEL;
                        batch.value[0] = {8'd0, val};
                    end
                    left_next = left_dec;
                    if (left_dec == 5'd0) begin
                        do_end = 1'b1;
                    end else begin
                        do_req    = 1'b1;
                        req_off   = off_inc;
                        req_phase = PH_UNITENT;
                    end
                end
                default:
                begin
                    do_end = 1'b1;
                end
            endcase
        end

        // a request past the rom window ends the walk instead
        if (do_req && req_off[AW]) begin
            do_req     = 1'b0;
            do_end     = 1'b1;
            end_status = ST_RANGE;
        end

        off32 = 32'(req_off[AW-1:0]);
        if (do_req) begin
            off_next          = req_off[AW-1:0];
            phase_next        = req_phase;
            batch.next_offset = off32[9:0];
            batch.fetch_more  = 1'b1;
            batch.walk_status = ST_BUSY;
        end else if (do_end) begin
            phase_next        = PH_IDLE;
            batch.next_offset = '0;
            batch.fetch_more  = 1'b0;
            batch.walk_status = end_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            off_reg   <= '0;
            left_reg  <= '0;
            udp_reg   <= '0;
            vend_reg  <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            left_reg  <= left_next;
            udp_reg   <= udp_next;
            vend_reg  <= vend_next;
        end
    end

endmodule

/* rtl/core/config_rom_directory_parser_top.sv */
// top level of the config rom directory parser: walk decode and record output buffer
//
//  channel | ports                           | content
//  --------+---------------------------------+-----------------------------------------
//  input   | quad_valid, quad_stall, quad    | start command or one fetched quadlet
//  output  | res_valid, res_stall, res       | one record with next offset and status
//
// a word is decoded in the cycle it is taken; its records leave the record shift
// buffer one per cycle from the next cycle on while the output is not stalled, and
// the input stays stalled until the last of them leaves (seven records for the
// capability quadlet, two for the vendor quadlet, one otherwise, none for a word dropped while idle)
// the next word is taken in the same cycle the last record of the previous one leaves
// reset clears the walk state and empties the buffer; there is no clearing pass
// a stall on the output holds the current record and stalls the input behind it
module config_rom_directory_parser_top #(
    parameter int MAX_DIR_ENTRIES = 16,
    parameter int ROM_ADDR_BITS   = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            quad_valid,
    output logic            quad_stall,
    input  crdp_pkg::quad_t quad,
    output logic            res_valid,
    input  logic            res_stall,
    output crdp_pkg::res_t  res
);
    import crdp_pkg::*;

    `include "config_rom_directory_parser_top_assert.svh"

    batch_t batch;
    logic   take;
    logic   res_fire;

    logic [2:0]                 left_reg;
    logic [NUM_SLOTS-1:0][3:0]  kind_reg;
    logic [NUM_SLOTS-1:0][31:0] value_reg;
    logic                       decoded_reg;
    logic [9:0]                 offset_reg;
    logic                       more_reg;
    logic [2:0]                 status_reg;

    crdp_walk #(
        .MAX_DIR_ENTRIES (MAX_DIR_ENTRIES),
        .ROM_ADDR_BITS   (ROM_ADDR_BITS)
    ) u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .quad  (quad),
        .batch (batch)
    );

    assign res_valid  = left_reg != 3'd0;
    assign res_fire   = res_valid && !res_stall;
    assign quad_stall = res_valid && !(res_fire && left_reg == 3'd1);
    assign take       = quad_valid && !quad_stall;

    always_comb
    begin
        res.record_valid = decoded_reg;
        res.record_kind  = kind_reg[0];
        res.record_value = value_reg[0];
        res.next_offset  = offset_reg;
        res.fetch_more   = more_reg;
        res.walk_status  = status_reg;
        res.last         = left_reg == 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (take)
        begin
            left_reg <= batch.count;
        end
        else if (res_fire)
        begin
            left_reg <= left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg    <= batch.kind;
            value_reg   <= batch.value;
            decoded_reg <= batch.decoded;
            offset_reg  <= batch.next_offset;
            more_reg    <= batch.fetch_more;
            status_reg  <= batch.walk_status;
        end
        else if (res_fire)
        begin
            kind_reg  <= {4'd0, kind_reg[NUM_SLOTS-1:1]};
            value_reg <= {32'd0, value_reg[NUM_SLOTS-1:1]};
        end
    end

    `CRDP_ASSERT_IMP(a_take_only_at_last, take && res_valid, res_fire && res.last, "word taken while records remain")
    `CRDP_ASSERT_NXT(a_records_continue, res_fire && !res.last, res_valid, "record batch cut short")
    `CRDP_ASSERT_IMP(a_more_means_busy, res_valid && res.fetch_more, res.walk_status == ST_BUSY, "fetch requested on a finished walk")
    `CRDP_ASSERT_IMP(a_end_offset_zero, res_valid && !res.fetch_more, res.next_offset == 10'd0, "finished walk with nonzero offset")
    `CRDP_ASSERT_IMP(a_empty_record_alone, res_valid && !res.record_valid, res.last, "empty record not alone")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the config rom directory parser
module testbench;
    import crdp_pkg::*;

    localparam int MAX_DIR_ENTRIES = 16;
    localparam int ROM_ADDR_BITS   = 10;
    localparam int WINDOW_BYTES    = 1 << ROM_ADDR_BITS;
    localparam int RANDOM_WORDS    = 196;
    localparam int N_DIRECTED      = 24;

    localparam logic        ACT_START     = 1'b0;
    localparam logic        ACT_WORD      = 1'b1;
    localparam logic [31:0] ROM_MAGIC     = 32'h3133_3934;
    localparam logic [7:0]  BUS_INFO_LEN  = 8'h04;
    localparam logic [7:0]  KEY_VENDOR    = 8'h03;
    localparam logic [7:0]  KEY_NODECAPS  = 8'h0c;
    localparam logic [7:0]  KEY_TEXT_LEAF = 8'h81;
    localparam logic [7:0]  KEY_UNIT_DIR  = 8'hd1;
    localparam logic [7:0]  KEY_SPEC      = 8'h12;
    localparam logic [7:0]  KEY_SWVER     = 8'h13;
    localparam logic [7:0]  KEY_MODEL     = 8'h17;

    typedef enum logic [3:0] {
        REC_VENDOR, REC_IRM, REC_CYCLEMASTER, REC_ISO, REC_BUSMGR, REC_ACCURACY,
        REC_PAYLOAD, REC_SPEED, REC_GUIDHI, REC_GUIDLO, REC_NODECAPS, REC_SPEC,
        REC_SWVER, REC_MODEL, REC_TEXTLEAF, REC_VENDOR_MISMATCH
    } rec_kind_e;

    typedef enum logic [3:0] {
        WALK_IDLE, WALK_HDR, WALK_MAGIC, WALK_CAPS, WALK_VENDOR, WALK_GUIDLO,
        WALK_ROOT_HDR, WALK_ROOT_ENT, WALK_UNIT_HDR, WALK_UNIT_ENT
    } walk_phase_e;

    typedef struct packed {
        quad_t word;
        logic  typed;
        res_t  want;
    } dir_row_t;

    localparam res_t NO_REC = '0;

    // directed words; typed rows carry the one record they must produce
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // delivery while idle is dropped
        '{'{ACT_WORD,  32'hffff_ffff, 1'b1}, 1'b0, NO_REC},
        '{'{ACT_START, 32'h0000_0000, 1'b0}, 1'b1,
          '{1'b0, 4'd0, 32'd0, 10'd0, 1'b1, ST_BUSY, 1'b1}},
        '{'{ACT_WORD,  32'h0000_0000, 1'b1}, 1'b1,
          '{1'b0, 4'd0, 32'd0, 10'd0, 1'b0, ST_FETCHERR, 1'b1}},
        '{'{ACT_START, 32'hffff_ffff, 1'b1}, 1'b0, NO_REC},
        // short rom: vendor only
        '{'{ACT_WORD,  32'h05ab_cdef, 1'b0}, 1'b1,
          '{1'b1, REC_VENDOR, 32'h00ab_cdef, 10'd0, 1'b0, ST_DONE, 1'b1}},
        '{'{ACT_START, 32'h0000_0000, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'h0400_0000, 1'b0}, 1'b0, NO_REC},
        // restart in the middle of a walk
        '{'{ACT_START, 32'h0000_0000, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'h04ff_ffff, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'h3133_3935, 1'b0}, 1'b1,
          '{1'b0, 4'd0, 32'd0, 10'd0, 1'b0, ST_BADMAGIC, 1'b1}},
        '{'{ACT_START, 32'h0000_0000, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'h0400_1234, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  ROM_MAGIC,     1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'hffff_ffff, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'h1234_5678, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'hffff_ffff, 1'b0}, 1'b0, NO_REC},
        // root length far above the cap
        '{'{ACT_WORD,  32'hffff_0000, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'h0c00_0fff, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'h0312_3456, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'h0300_0000, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'h8100_0002, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'hd100_0001, 1'b0}, 1'b0, NO_REC},
        '{'{ACT_WORD,  32'hd100_0004, 1'b0}, 1'b0, NO_REC},
        // unit pointer far outside the window
        '{'{ACT_WORD,  32'hd1ff_ffff, 1'b0}, 1'b1,
          '{1'b0, 4'd0, 32'd0, 10'd0, 1'b0, ST_RANGE, 1'b1}}
    };

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  quad_valid = 1'b0;
    logic  quad_stall;
    quad_t quad       = '0;
    logic  res_valid;
    logic  res_stall  = 1'b0;
    res_t  res;

    always #5 clk = ~clk;

    config_rom_directory_parser_top #(
        .MAX_DIR_ENTRIES (MAX_DIR_ENTRIES),
        .ROM_ADDR_BITS   (ROM_ADDR_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .quad_valid (quad_valid),
        .quad_stall (quad_stall),
        .quad       (quad),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    // walk state as the block should hold it
    walk_phase_e walk_phase   = WALK_IDLE;
    logic [31:0] walk_offset  = '0;
    logic [4:0]  dir_left     = '0;
    logic [31:0] unit_dir_ptr = '0;
    logic [23:0] info_vendor  = '0;

    logic [9:0]  step_next;
    logic        step_more;
    logic [2:0]  step_status;
    rec_kind_e   step_kind [$];
    logic [31:0] step_value [$];
    res_t        word_recs [$];
    res_t        expected_recs [$];

    int errors        = 0;
    int words_sent    = 0;
    int random_words  = 0;
    int records_seen  = 0;
    int send_burst    = 0;
    int stall_left    = 0;
    int stall_burst   = 0;
    int walks_ended [0:7];
    res_t head_rec;

    task automatic end_walk_with(input logic [2:0] status);
        walk_phase  = WALK_IDLE;
        step_next   = '0;
        step_more   = 1'b0;
        step_status = status;
    endtask

    task automatic fetch_at(input logic [31:0] off, input walk_phase_e phase);
        if (off >= WINDOW_BYTES)
            end_walk_with(ST_RANGE);
        else
        begin
            walk_offset = off;
            walk_phase  = phase;
            step_next   = off[9:0];
            step_more   = 1'b1;
            step_status = ST_BUSY;
        end
    endtask

    task automatic leave_root();
        if (unit_dir_ptr != 0)
            fetch_at(unit_dir_ptr, WALK_UNIT_HDR);
        else
            end_walk_with(ST_DONE);
    endtask

    function automatic logic [4:0] capped_len(input logic [15:0] len);
        return (len > MAX_DIR_ENTRIES) ? 5'(MAX_DIR_ENTRIES) : len[4:0];
    endfunction

    task automatic add_record(input rec_kind_e kind, input logic [31:0] value);
        step_kind.push_back(kind);
        step_value.push_back(value);
    endtask

    // advance the walk by one accepted word and collect the records it causes
    task automatic walk_rom_word(input quad_t q);
        logic [7:0]  key;
        logic [23:0] val;
        logic [31:0] ptr;
        logic [31:0] w;
        res_t        r;
        w   = q.rom_word;
        key = w[31:24];
        val = w[23:0];
        ptr = walk_offset + {6'd0, val, 2'b00};
        step_kind.delete();
        step_value.delete();
        word_recs.delete();
        step_next   = '0;
        step_more   = 1'b0;
        step_status = ST_BUSY;
        if (q.action == ACT_WORD && walk_phase == WALK_IDLE)
            return;
        if (q.action == ACT_START)
        begin
            dir_left     = '0;
            unit_dir_ptr = '0;
            info_vendor  = '0;
            fetch_at(32'd0, WALK_HDR);
        end
        else if (q.fetch_failed)
            end_walk_with(ST_FETCHERR);
        else
        begin
            case (walk_phase)
                WALK_HDR:
                    if (key != BUS_INFO_LEN)
                    begin
                        add_record(REC_VENDOR, {8'd0, val});
                        end_walk_with(ST_DONE);
                    end
                    else
                        fetch_at(walk_offset + 4, WALK_MAGIC);
                WALK_MAGIC:
                    if (w != ROM_MAGIC)
                        end_walk_with(ST_BADMAGIC);
                    else
                        fetch_at(walk_offset + 4, WALK_CAPS);
                WALK_CAPS:
                begin
                    add_record(REC_IRM,         {31'd0, w[31]});
                    add_record(REC_CYCLEMASTER, {31'd0, w[30]});
                    add_record(REC_ISO,         {31'd0, w[29]});
                    add_record(REC_BUSMGR,      {31'd0, w[28]});
                    add_record(REC_ACCURACY,    {24'd0, w[23:16]});
                    add_record(REC_PAYLOAD,     32'd2 << w[15:12]);
                    add_record(REC_SPEED,       {29'd0, w[2:0]});
                    fetch_at(walk_offset + 4, WALK_VENDOR);
                end
                WALK_VENDOR:
                begin
                    info_vendor = w[31:8];
                    add_record(REC_VENDOR, {8'd0, w[31:8]});
                    add_record(REC_GUIDHI, {24'd0, w[7:0]});
                    fetch_at(walk_offset + 4, WALK_GUIDLO);
                end
                WALK_GUIDLO:
                begin
                    add_record(REC_GUIDLO, w);
                    fetch_at(walk_offset + 4, WALK_ROOT_HDR);
                end
                WALK_ROOT_HDR:
                begin
                    dir_left = capped_len(w[31:16]);
                    if (dir_left == 0)
                        leave_root();
                    else
                        fetch_at(walk_offset + 4, WALK_ROOT_ENT);
                end
                WALK_ROOT_ENT:
                    if ((key == KEY_UNIT_DIR || key == KEY_TEXT_LEAF) && ptr >= WINDOW_BYTES)
                        end_walk_with(ST_RANGE);
                    else
                    begin
                        if (key == KEY_NODECAPS)
                            add_record(REC_NODECAPS, {8'd0, val});
                        else if (key == KEY_VENDOR)
                        begin
                            if (val != info_vendor)
                                add_record(REC_VENDOR_MISMATCH, {8'd0, val});
                        end
                        else if (key == KEY_UNIT_DIR)
                            unit_dir_ptr = ptr;
                        else if (key == KEY_TEXT_LEAF)
                            add_record(REC_TEXTLEAF, ptr);
                        dir_left = dir_left - 5'd1;
                        if (dir_left == 0)
                            leave_root();
                        else
                            fetch_at(walk_offset + 4, WALK_ROOT_ENT);
                    end
                WALK_UNIT_HDR:
                begin
                    dir_left = capped_len(w[31:16]);
                    if (dir_left == 0)
                        end_walk_with(ST_DONE);
                    else
                        fetch_at(walk_offset + 4, WALK_UNIT_ENT);
                end
                WALK_UNIT_ENT:
                begin
                    if (key == KEY_SPEC)
                        add_record(REC_SPEC, {8'd0, val});
                    else if (key == KEY_SWVER)
                        add_record(REC_SWVER, {8'd0, val});
                    else if (key == KEY_MODEL)
                        add_record(REC_MODEL, {8'd0, val});
                    dir_left = dir_left - 5'd1;
                    if (dir_left == 0)
                        end_walk_with(ST_DONE);
                    else
                        fetch_at(walk_offset + 4, WALK_UNIT_ENT);
                end
                default:
                    end_walk_with(ST_DONE);
            endcase
        end
        for (int i = 0; i < step_kind.size(); i++)
        begin
            r.record_valid = 1'b1;
            r.record_kind  = step_kind[i];
            r.record_value = step_value[i];
            r.next_offset  = step_next;
            r.fetch_more   = step_more;
            r.walk_status  = step_status;
            r.last         = (i == step_kind.size() - 1);
            word_recs.push_back(r);
        end
        if (word_recs.size() == 0)
        begin
            r             = '0;
            r.next_offset = step_next;
            r.fetch_more  = step_more;
            r.walk_status = step_status;
            r.last        = 1'b1;
            word_recs.push_back(r);
        end
    endtask

    function automatic logic [15:0] pick_dir_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 18)
            return 16'($urandom_range(MAX_DIR_ENTRIES, 16'hffff));
        return 16'($urandom_range(1, 5));
    endfunction

    // mostly well-formed words for the phase the walk is in, some noise
    task automatic pick_walk_word(output quad_t q);
        int          r;
        int          room;
        logic [23:0] val;
        r              = $urandom_range(0, 99);
        q.action       = ACT_WORD;
        q.rom_word     = $urandom;
        q.fetch_failed = 1'b0;
        if (walk_phase == WALK_IDLE || r < 3)
        begin
            if (walk_phase != WALK_IDLE || r < 90)
                q.action = ACT_START;
            q.fetch_failed = 1'($urandom_range(0, 1));
        end
        else if (r < 6)
            q.fetch_failed = 1'b1;
        else if (r >= 9)
        begin
            case (walk_phase)
                WALK_HDR:
                    if (r < 95)
                        q.rom_word[31:24] = BUS_INFO_LEN;
                WALK_MAGIC:
                    if (r < 95)
                        q.rom_word = ROM_MAGIC;
                WALK_ROOT_HDR, WALK_UNIT_HDR:
                    q.rom_word[31:16] = pick_dir_len();
                WALK_ROOT_ENT:
                begin
                    // smallest offset value that points past the window
                    room = (WINDOW_BYTES - int'(walk_offset)) / 4;
                    case ($urandom_range(0, 5))
                        0: q.rom_word[31:24] = KEY_NODECAPS;
                        1:
                        begin
                            q.rom_word[31:24] = KEY_VENDOR;
                            if ($urandom_range(0, 1))
                                q.rom_word[23:0] = info_vendor;
                        end
                        2, 3, 4:
                        begin
                            q.rom_word[31:24] = $urandom_range(0, 1) ? KEY_UNIT_DIR
                                                                     : KEY_TEXT_LEAF;
                            case ($urandom_range(0, 9))
                                0: val = 24'(room - 1);
                                1: val = 24'(room);
                                2: val = 24'($urandom_range(room, 24'hff_ffff));
                                default: val = 24'($urandom_range(1, 24));
                            endcase
                            q.rom_word[23:0] = val;
                        end
                        default: ;
                    endcase
                end
                WALK_UNIT_ENT:
                    case ($urandom_range(0, 3))
                        0: q.rom_word[31:24] = KEY_SPEC;
                        1: q.rom_word[31:24] = KEY_SWVER;
                        2: q.rom_word[31:24] = KEY_MODEL;
                        default: ;
                    endcase
                default: ;
            endcase
        end
    endtask

    // called and returns at a falling edge
    task automatic send_word(input quad_t q, input logic typed, input res_t want);
        int gap;
        if (send_burst > 0)
        begin
            gap = 0;
            send_burst--;
        end
        else
        begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0)
                send_burst = $urandom_range(10, 30);
        end
        if (gap > 0)
        begin
            quad_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        quad_valid <= 1'b1;
        quad       <= q;
        @(posedge clk);
        while (quad_stall)
            @(posedge clk);
        walk_rom_word(q);
        if (typed)
            expected_recs.push_back(want);
        else
            foreach (word_recs[i])
                expected_recs.push_back(word_recs[i]);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else
            res_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            records_seen++;
            if (expected_recs.size() == 0)
            begin
                errors++;
                $display("%0t: record with nothing expected, got kind %0d value 0x%0h",
                         $time, res.record_kind, res.record_value);
            end
            else
            begin
                head_rec = expected_recs.pop_front();
                check_field("record_valid", 32'(head_rec.record_valid),
                            32'(res.record_valid));
                check_field("record_kind",  32'(head_rec.record_kind),
                            32'(res.record_kind));
                check_field("record_value", head_rec.record_value, res.record_value);
                check_field("next_offset",  32'(head_rec.next_offset),
                            32'(res.next_offset));
                check_field("fetch_more",   32'(head_rec.fetch_more),
                            32'(res.fetch_more));
                check_field("walk_status",  32'(head_rec.walk_status),
                            32'(res.walk_status));
                check_field("last",         32'(head_rec.last), 32'(res.last));
            end
            if (res.last && res.walk_status != ST_BUSY)
                walks_ended[res.walk_status]++;
            if (stall_burst > 0)
            begin
                stall_left = 0;
                stall_burst--;
            end
            else
            begin
                stall_left = $urandom_range(0, 9);
                if ($urandom_range(0, 19) == 0)
                    stall_burst = $urandom_range(10, 40);
            end
        end
    end

    initial
    begin
        quad_t q;
        int    guard;
        foreach (walks_ended[i])
            walks_ended[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
        while (random_words < RANDOM_WORDS)
        begin
            pick_walk_word(q);
            // words dropped while idle do not count
            if (!(q.action == ACT_WORD && walk_phase == WALK_IDLE))
                random_words++;
            send_word(q, 1'b0, NO_REC);
        end
        quad_valid <= 1'b0;
        guard = 0;
        while (expected_recs.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        if (expected_recs.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected records never arrived", $time, expected_recs.size());
        end
        $display("sent %0d words (%0d in random walks), checked %0d records",
                 words_sent, random_words, records_seen);
        $display("walks ended: %0d done, %0d bad magic, %0d fetch error, %0d out of window",
                 walks_ended[ST_DONE], walks_ended[ST_BADMAGIC],
                 walks_ended[ST_FETCHERR], walks_ended[ST_RANGE]);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
